/* design/cmdd_pkg.sv */
// shared types and constants for the command message deframer
// no dependencies

package cmdd_pkg;

    // result kind codes
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_EMPTY     = 2'd1;
    localparam logic [1:0] KIND_MALFORMED = 2'd2;

    // header sizes and limits
    localparam int          LEN_BYTES         = 4;
    localparam logic [31:0] MSG_HDR_SIZE      = 32'd4;
    localparam logic [31:0] EXT_HDR_SIZE      = 32'd5;
    localparam logic [31:0] EXT_MIN_LEN       = 32'd6;
    localparam logic [7:0]  SHORT_MIN_LEN     = 8'd2;
    localparam logic [30:0] EXT_MIN_REMAINING = 31'd5;

    // default depth of the result queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // parser phase
    typedef enum logic [2:0] {
        PH_LEN,
        PH_HDR,
        PH_EXT,
        PH_ID,
        PH_DATA,
        PH_DROP
    } phase_t;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] command_id;
        logic [7:0] data_byte;
        logic       first_of_command;
        logic       last_of_command;
    } result_t;

endpackage

/* design/cmdd_front.sv */
// front part: parses wire bytes into messages and commands, one byte per cycle while byte_valid is high
// depends on cmdd_pkg

module cmdd_front
    import cmdd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_in,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [30:0] msg_rem_reg, msg_rem_next;
    logic [31:0] cmd_rem_reg, cmd_rem_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] len_acc_reg, len_acc_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic        data_seen_reg, data_seen_next;

    logic [31:0] acc_shift;
    logic [30:0] rem_dec;
    logic [31:0] cmd_dec;
    logic [31:0] ext_limit;
    logic        hdr_done;

    // shared datapath terms
    always_comb
    begin
        acc_shift = {len_acc_reg[23:0], byte_in};
        rem_dec   = msg_rem_reg - 31'd1;
        cmd_dec   = (cmd_rem_reg != 32'd0) ? (cmd_rem_reg - 32'd1) : 32'd0;
        ext_limit = {1'b0, rem_dec} + EXT_HDR_SIZE;
        hdr_done  = (hdr_cnt_reg == 2'(LEN_BYTES - 1));
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        msg_rem_next   = msg_rem_reg;
        cmd_rem_next   = cmd_rem_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        len_acc_next   = len_acc_reg;
        cur_id_next    = cur_id_reg;
        data_seen_next = data_seen_reg;
        if (byte_valid)
        begin
            if (phase_reg == PH_LEN)
            begin
                // message length, big-endian
                if (hdr_done)
                begin
                    hdr_cnt_next = 2'd0;
                    len_acc_next = 32'd0;
                    if (!acc_shift[31] && (acc_shift > MSG_HDR_SIZE))
                    begin
                        msg_rem_next = 31'(acc_shift - MSG_HDR_SIZE);
                        phase_next   = PH_HDR;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    len_acc_next = acc_shift;
                end
            end
            else
            begin
                msg_rem_next = rem_dec;
                case (phase_reg)
                    PH_HDR:
                    begin
                        if ((byte_in == 8'd0) && (msg_rem_reg >= EXT_MIN_REMAINING))
                        begin
                            phase_next   = PH_EXT;
                            hdr_cnt_next = 2'd0;
                            len_acc_next = 32'd0;
                        end
                        else if ((byte_in < SHORT_MIN_LEN) ||
                                 ({23'd0, byte_in} > msg_rem_reg))
                        begin
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            cmd_rem_next = {24'd0, byte_in} - 32'd1;
                            phase_next   = PH_ID;
                        end
                    end
                    PH_EXT:
                    begin
                        if (hdr_done)
                        begin
                            hdr_cnt_next = 2'd0;
                            len_acc_next = 32'd0;
                            if ((acc_shift < EXT_MIN_LEN) || (acc_shift > ext_limit))
                            begin
                                phase_next = PH_DROP;
                            end
                            else
                            begin
                                cmd_rem_next = acc_shift - EXT_HDR_SIZE;
                                phase_next   = PH_ID;
                            end
                        end
                        else
                        begin
                            hdr_cnt_next = hdr_cnt_reg + 2'd1;
                            len_acc_next = acc_shift;
                        end
                    end
                    PH_ID:
                    begin
                        cur_id_next  = byte_in;
                        cmd_rem_next = cmd_dec;
                        if (cmd_dec == 32'd0)
                        begin
                            phase_next = PH_HDR;
                        end
                        else
                        begin
                            data_seen_next = 1'b0;
                            phase_next     = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        cmd_rem_next   = cmd_dec;
                        data_seen_next = 1'b1;
                        if (cmd_dec == 32'd0)
                        begin
                            phase_next = PH_HDR;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                // body used up: back to message length
                if (rem_dec == 31'd0)
                begin
                    phase_next   = PH_LEN;
                    hdr_cnt_next = 2'd0;
                    len_acc_next = 32'd0;
                    cmd_rem_next = 32'd0;
                end
            end
        end
    end

    // result of the current byte
    always_comb
    begin
        res_valid            = 1'b0;
        res.kind             = KIND_DATA;
        res.command_id       = 8'd0;
        res.data_byte        = 8'd0;
        res.first_of_command = 1'b1;
        res.last_of_command  = 1'b1;
        case (phase_reg)
            PH_HDR:
            begin
                if (!((byte_in == 8'd0) && (msg_rem_reg >= EXT_MIN_REMAINING)) &&
                    ((byte_in < SHORT_MIN_LEN) || ({23'd0, byte_in} > msg_rem_reg)))
                begin
                    res_valid = byte_valid;
                    res.kind  = KIND_MALFORMED;
                end
            end
            PH_EXT:
            begin
                if (hdr_done && ((acc_shift < EXT_MIN_LEN) || (acc_shift > ext_limit)))
                begin
                    res_valid = byte_valid;
                    res.kind  = KIND_MALFORMED;
                end
            end
            PH_ID:
            begin
                if (cmd_dec == 32'd0)
                begin
                    res_valid      = byte_valid;
                    res.kind       = KIND_EMPTY;
                    res.command_id = byte_in;
                end
            end
            PH_DATA:
            begin
                res_valid            = byte_valid;
                res.kind             = KIND_DATA;
                res.command_id       = cur_id_reg;
                res.data_byte        = byte_in;
                res.first_of_command = !data_seen_reg;
                res.last_of_command  = (cmd_dec == 32'd0);
            end
            default:
            begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            msg_rem_reg   <= 31'd0;
            cmd_rem_reg   <= 32'd0;
            hdr_cnt_reg   <= 2'd0;
            len_acc_reg   <= 32'd0;
            cur_id_reg    <= 8'd0;
            data_seen_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            msg_rem_reg   <= msg_rem_next;
            cmd_rem_reg   <= cmd_rem_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            len_acc_reg   <= len_acc_next;
            cur_id_reg    <= cur_id_next;
            data_seen_reg <= data_seen_next;
        end
    end

endmodule

/* design/cmdd_queue.sv */
// back part: result queue with a registered head that faces the output
// depends on cmdd_pkg

module cmdd_queue
    import cmdd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    full,
    input  logic    rd_en,
    output logic    head_valid,
    output result_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               head_valid_reg, head_valid_next;
    result_t            head_reg;
    logic               load;

    // move an item into the head register when it is free or being taken
    always_comb
    begin
        load            = (count_reg != '0) && (!head_valid_reg || rd_en);
        head_valid_next = load || (head_valid_reg && !rd_en);
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (load)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(wr_en) - CNT_W'(load);
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // registered read into the head
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            head_valid_reg <= head_valid_next;
        end
    end

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = head_valid_reg;
    assign head       = head_reg;

endmodule

/* design/command_message_deframer.sv */
// command message deframer: length-prefixed messages split into commands
// path: a result goes into the queue storage, then into the output head register
// throughput: one byte per cycle; the parser takes a byte every cycle while the
// result queue (QUEUE_DEPTH entries plus the head register) has room
// reset: asynchronous, active low; the parser waits for a message length
// depends on cmdd_pkg, cmdd_front, cmdd_queue

module command_message_deframer
    import cmdd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] wire_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] kind,
    output logic [7:0] command_id,
    output logic [7:0] data_byte,
    output logic       first_of_command,
    output logic       last_of_command
);

    logic    byte_accept;
    logic    res_valid;
    result_t res;
    logic    head_valid;
    result_t head;

    assign byte_accept = push && !full;

    // parser
    cmdd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .byte_in    (wire_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result queue and output head
    cmdd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (res_valid),
        .wr_data    (res),
        .full       (full),
        .rd_en      (pop && head_valid),
        .head_valid (head_valid),
        .head       (head)
    );

    // output ports
    assign empty            = !head_valid;
    assign kind             = head.kind;
    assign command_id       = head.command_id;
    assign data_byte        = head.data_byte;
    assign first_of_command = head.first_of_command;
    assign last_of_command  = head.last_of_command;

endmodule
